FILE: rtl/core/pwmps_pkg.sv
// shared types and constants of the pwm prescaler and period solver
package pwmps_pkg;

  // channel count and field widths
  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;
  localparam int MODE_W   = 3;
  localparam int FREQ_W   = 32;
  localparam int DUTY_W   = 17;
  localparam int PRE_W    = 4;
  localparam int PER_W    = 16;
  localparam int CMP_W    = 17;

  // command queue between front and back
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  // reset values
  localparam logic [FREQ_W-1:0] CLOCK_RESET = 32'd80000000;
  localparam logic [FREQ_W-1:0] FREQ_RESET  = 32'd1000;

  // solver limits
  localparam logic [DUTY_W-1:0] FULL_DUTY      = 17'd65536;
  localparam logic [PER_W-1:0]  PERIOD_MAX     = 16'd65535;
  localparam logic [FREQ_W-1:0] LOW_FREQ_LIMIT = 32'd100000;
  // lowest q >> i that still fits: minimum period plus one
  localparam logic [FREQ_W-1:0] MIN_LOW_V      = 32'd1001;
  localparam logic [FREQ_W-1:0] MIN_HIGH_V     = 32'd201;
  // highest q >> i that still fits: period max plus one
  localparam logic [FREQ_W-1:0] MAX_V          = 32'd65536;
  localparam logic [PRE_W-1:0]  LAST_DIV       = 4'd15;

  // command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_FREQ    = 3'd0,
    MODE_DUTY    = 3'd1,
    MODE_BOTH    = 3'd2,
    MODE_DISABLE = 3'd3,
    MODE_REAPPLY = 3'd4
  } mode_t;

  // one solve job: channel plus its settings after the update
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
  } job_t;

  // one solved result
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [PRE_W-1:0] pre;
    logic [PER_W-1:0] per;
    logic [CMP_W-1:0] cmp;
    logic             err;
  } res_t;

endpackage

FILE: rtl/core/pwmps_front.sv
// command front end: per-channel settings store and job issue
module pwmps_front import pwmps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [CH_W-1:0]   in_ch,
  input  logic [FREQ_W-1:0] in_freq,
  input  logic [DUTY_W-1:0] in_duty,
  output logic              push,
  output job_t              push_job,
  input  logic              q_full
);

  logic [FREQ_W-1:0] stored_frequency [CHANNELS];
  logic [DUTY_W-1:0] stored_duty      [CHANNELS];

  logic              take;
  logic              ch_ok;
  logic [DUTY_W-1:0] duty_sat;
  logic [FREQ_W-1:0] freq_next;
  logic [DUTY_W-1:0] duty_next;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign ch_ok    = int'(in_ch) < CHANNELS;
  assign duty_sat = (in_duty > FULL_DUTY) ? FULL_DUTY : in_duty;

  // new settings of the addressed channel
  always_comb begin
    freq_next = stored_frequency[in_ch];
    duty_next = stored_duty[in_ch];
    case (mode_t'(in_mode))
      MODE_FREQ: begin
        freq_next = in_freq;
      end
      MODE_DUTY: begin
        duty_next = duty_sat;
      end
      MODE_BOTH: begin
        freq_next = in_freq;
        duty_next = duty_sat;
      end
      MODE_DISABLE: begin
        duty_next = '0;
      end
      default: begin
      end
    endcase
  end

  // settings store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        stored_frequency[c] <= FREQ_RESET;
        stored_duty[c]      <= '0;
      end
    end else if (take && ch_ok) begin
      stored_frequency[in_ch] <= freq_next;
      stored_duty[in_ch]      <= duty_next;
    end
  end

  // job to the queue; channels out of range are dropped
  assign push          = take && ch_ok;
  assign push_job.ch   = in_ch;
  assign push_job.freq = freq_next;
  assign push_job.duty = duty_next;

endmodule

FILE: rtl/core/pwmps_queue.sv
// short job queue between command front end and solver
module pwmps_queue import pwmps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QDEPTH);
  assign valid   = count != '0;
  assign pop_job = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/pwmps_back.sv
// solver: serial divide, prescaler search, compare multiply, result register
module pwmps_back import pwmps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [FREQ_W-1:0] clock_hz,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH,
    ST_MUL,
    ST_DONE
  } state_t;

  state_t            state;
  job_t              job;
  logic [FREQ_W-1:0] rem;
  logic [FREQ_W-1:0] dq;
  logic [4:0]        cnt;
  logic [PRE_W-1:0]  idx;
  logic [PRE_W-1:0]  pre;
  logic [PER_W-1:0]  per;
  logic              err;
  logic [CMP_W-1:0]  cmp;

  logic [FREQ_W:0]   rem_sh;
  logic              rem_ge;
  logic [FREQ_W-1:0] min_v;
  logic              fits;
  logic [FREQ_W-1:0] v_dec;
  logic [CMP_W-1:0]  per_inc;
  logic [2*CMP_W-1:0] prod;

  // one restoring divide step
  assign rem_sh = {rem, dq[FREQ_W-1]};
  assign rem_ge = rem_sh >= {1'b0, job.freq};

  // range test on q >> idx, held in dq during the search
  assign min_v = (job.freq < LOW_FREQ_LIMIT) ? MIN_LOW_V : MIN_HIGH_V;
  assign fits  = (dq >= min_v) && (dq <= MAX_V);
  assign v_dec = dq - 1'b1;

  // compare value
  assign per_inc = {1'b0, per} + 1'b1;
  assign prod    = job.duty * per_inc;

  assign pop = (state == ST_IDLE) && q_valid;

  // sequencer with result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result register handshake
      if ((state == ST_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            job <= q_job;
            if (q_job.freq == '0) begin
              pre   <= '0;
              per   <= PERIOD_MAX;
              err   <= 1'b1;
              state <= ST_MUL;
            end else begin
              rem   <= '0;
              dq    <= clock_hz;
              cnt   <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem <= rem_ge ? FREQ_W'(rem_sh - {1'b0, job.freq}) : rem_sh[FREQ_W-1:0];
          dq  <= {dq[FREQ_W-2:0], rem_ge};
          cnt <= cnt + 1'b1;
          idx <= '0;
          if (cnt == 5'd31) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (fits) begin
            pre   <= idx;
            per   <= v_dec[PER_W-1:0];
            err   <= 1'b0;
            state <= ST_MUL;
          end else if (idx == LAST_DIV) begin
            pre <= '0;
            err <= 1'b1;
            if (dq == '0) begin
              per <= '0;
            end else if (dq > MAX_V) begin
              per <= PERIOD_MAX;
            end else begin
              per <= v_dec[PER_W-1:0];
            end
            state <= ST_MUL;
          end else begin
            dq  <= dq >> 1;
            idx <= idx + 1'b1;
          end
        end
        ST_MUL: begin
          cmp   <= prod[CMP_W+15:16];
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_res.ch  <= job.ch;
            out_res.pre <= pre;
            out_res.per <= per;
            out_res.cmp <= cmp;
            out_res.err <= err;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/pwm_prescaler_period_solver.sv
// top level of the pwm prescaler and period solver
// a zero frequency skips the divider and search; else the job passes the serial divider,
//   then up to 16 prescaler search steps, then the compare multiply and result register
// the back end solves one command at a time and takes the next only once the last result
//   is in the result register; the two-entry queue lets the front take commands meanwhile
// reset: rst synchronous, high; clock_hz returns to 80000000, every channel to
//   frequency 1000 and duty 0, queue and result register empty
module pwm_prescaler_period_solver import pwmps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration: clock_hz
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // channel_index, frequency, duty_q16, zero pad
  input  logic [2:0]  s_axis_tuser,   // mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_channel, prescale_log2, period, compare, zero pad
  output logic        m_axis_tuser    // range_error
);

  logic [FREQ_W-1:0] clock_hz;
  logic              push;
  job_t              push_job;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  job_t              q_job;
  res_t              res;

  // clock frequency register
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
    end else if (cfg_we) begin
      clock_hz <= cfg_wdata;
    end
  end

  // front end
  pwmps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_mode  (s_axis_tuser),
    .in_ch    (s_axis_tdata[1:0]),
    .in_freq  (s_axis_tdata[33:2]),
    .in_duty  (s_axis_tdata[50:34]),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // job queue
  pwmps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_job  (q_job)
  );

  // solver back end
  pwmps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .clock_hz  (clock_hz),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // result packing
  assign m_axis_tdata = {1'b0, res.cmp, res.per, res.pre, res.ch};
  assign m_axis_tuser = res.err;

`ifndef SYNTHESIS
  // a solved period never sits below the smallest minimum
  a_period_floor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[21:6] >= 16'd200)
    else $error("solved period below minimum");

  // compare never exceeds period plus one
  a_cmp_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> {1'b0, m_axis_tdata[38:22]} <= {2'b0, m_axis_tdata[21:6]} + 18'd1)
    else $error("compare above period plus one");

  // an error result carries prescaler zero
  a_err_pre: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:2] == 4'd0)
    else $error("error result with nonzero prescaler");

  // the queue is not written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("job queue overflow");
`endif

endmodule

FILE: tb/sv/pwm_solver_checker.sv
// checker for the pwm prescaler and period solver: predicts each result and compares it
module pwm_solver_checker import pwmps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // channel_index, frequency, duty_q16, zero pad
  input  logic [2:0]  s_axis_tuser,   // mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // out_channel, prescale_log2, period, compare, zero pad
  input  logic        m_axis_tuser,   // range_error
  output int          errors,
  output int          outstanding,
  output int          results_seen
);

  // predicted copy of the block state
  logic [FREQ_W-1:0] clock_hz;
  logic [FREQ_W-1:0] chan_freq [CHANNELS];
  logic [DUTY_W-1:0] chan_duty [CHANNELS];
  res_t              pending_settings [$];
  int                err_cnt;
  int                seen_cnt;

  initial begin
    errors       = 0;
    outstanding  = 0;
    results_seen = 0;
    err_cnt      = 0;
    seen_cnt     = 0;
  end

  // prescaler search, period and compare for one channel
  function automatic res_t solve_settings(logic [FREQ_W-1:0] clk_hz, logic [CH_W-1:0] ch,
                                          logic [FREQ_W-1:0] freq, logic [DUTY_W-1:0] duty);
    res_t        r;
    logic [31:0] q;
    logic [31:0] v;
    logic [31:0] lowest;
    logic [63:0] prod;
    bit          found;
    r.ch  = ch;
    r.pre = '0;
    r.per = '0;
    r.err = 1'b1;
    found = 1'b0;
    if (freq == '0) begin
      // zero frequency: no division, full period
      r.per = PERIOD_MAX;
    end else begin
      q      = clk_hz / freq;
      lowest = (freq < LOW_FREQ_LIMIT) ? MIN_LOW_V : MIN_HIGH_V;
      for (int i = 0; i <= int'(LAST_DIV); i++) begin
        v = q >> i;
        if (!found && v >= lowest && v <= MAX_V) begin
          r.pre = PRE_W'(i);
          r.per = PER_W'(v - 32'd1);
          r.err = 1'b0;
          found = 1'b1;
        end
      end
      // no divider fits: take the last one, clamped
      if (!found) begin
        v = q >> LAST_DIV;
        if (v == '0)
          r.per = '0;
        else if (v > MAX_V)
          r.per = PERIOD_MAX;
        else
          r.per = PER_W'(v - 32'd1);
      end
    end
    prod  = 64'(duty) * (64'(r.per) + 64'd1);
    r.cmp = CMP_W'(prod >> 16);
    return r;
  endfunction

  always @(posedge clk) begin
    logic [CH_W-1:0]   ch;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    res_t              want;
    res_t              got;
    if (rst) begin
      clock_hz = CLOCK_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_freq[c] = FREQ_RESET;
        chan_duty[c] = '0;
      end
      pending_settings.delete();
    end else begin
      if (cfg_we)
        clock_hz = cfg_wdata;

      // result transfer: compare with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        seen_cnt++;
        got.ch  = m_axis_tdata[1:0];
        got.pre = m_axis_tdata[5:2];
        got.per = m_axis_tdata[21:6];
        got.cmp = m_axis_tdata[38:22];
        got.err = m_axis_tuser;
        if (pending_settings.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, actual %p", $time, got);
        end else begin
          want = pending_settings.pop_front();
          if (got.ch !== want.ch) begin
            err_cnt++;
            $display("%0t: out_channel expected %0d actual %0d", $time, want.ch, got.ch);
          end
          if (got.pre !== want.pre) begin
            err_cnt++;
            $display("%0t: prescale_log2 expected %0d actual %0d", $time, want.pre, got.pre);
          end
          if (got.per !== want.per) begin
            err_cnt++;
            $display("%0t: period expected %0d actual %0d", $time, want.per, got.per);
          end
          if (got.cmp !== want.cmp) begin
            err_cnt++;
            $display("%0t: compare expected %0d actual %0d", $time, want.cmp, got.cmp);
          end
          if (got.err !== want.err) begin
            err_cnt++;
            $display("%0t: range_error expected %0d actual %0d", $time, want.err, got.err);
          end
        end
      end

      // command transfer: update stored settings and predict
      if (s_axis_tvalid && s_axis_tready) begin
        ch   = s_axis_tdata[1:0];
        freq = s_axis_tdata[33:2];
        duty = s_axis_tdata[50:34];
        if (duty > FULL_DUTY)
          duty = FULL_DUTY;
        case (s_axis_tuser)
          MODE_FREQ: chan_freq[ch] = freq;
          MODE_DUTY: chan_duty[ch] = duty;
          MODE_BOTH: begin
            chan_freq[ch] = freq;
            chan_duty[ch] = duty;
          end
          MODE_DISABLE: chan_duty[ch] = '0;
          default: ;
        endcase
        pending_settings.push_back(solve_settings(clock_hz, ch, chan_freq[ch], chan_duty[ch]));
      end
    end
    errors       <= err_cnt;
    results_seen <= seen_cnt;
    outstanding  <= pending_settings.size();
  end

endmodule

FILE: tb/sv/tb.sv
// top of the pwm prescaler and period solver bench: clock, reset, stimulus and verdict
module tb;
  import pwmps_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE       = 80;
  localparam int LONG_HOLD    = 600;
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // channel_index, frequency, duty_q16, zero pad
  logic [2:0]  s_axis_tuser = '0;   // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // out_channel, prescale_log2, period, compare, zero pad
  logic        m_axis_tuser;        // range_error

  int          errors;
  int          outstanding;
  int          results_seen;
  int          cycle_count = 0;
  logic [31:0] clock_now = CLOCK_RESET;

  always #1 clk = ~clk;

  pwm_prescaler_period_solver DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pwm_solver_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .outstanding   (outstanding),
    .results_seen  (results_seen)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off once results are flowing
  initial begin
    int  r;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && results_seen >= 100) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (r < 60) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else if (r < 95) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  // one command transfer, then a random gap
  task automatic send_cmd(logic [MODE_W-1:0] mode, logic [CH_W-1:0] ch,
                          logic [FREQ_W-1:0] freq, logic [DUTY_W-1:0] duty);
    int r;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, duty, freq, ch};
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
    r = $urandom_range(0, 99);
    if (r < 55)
      gap = 0;
    else if (r < 92)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(10, 60);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every result, then let the solver settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_clock(logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    clock_now = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // frequency mix: divisions landing on each prescaler, range edges, noise
  function automatic logic [31:0] pick_freq(logic [31:0] clk_hz);
    int          r;
    longint      q_goal;
    logic [31:0] edges [6];
    edges = '{32'd1000, 32'd1001, 32'd200, 32'd201, 32'd65536, 32'd65537};
    r = $urandom_range(0, 19);
    if (r == 0)
      return '0;
    if (r <= 3)
      return $urandom;
    if (r <= 5)
      return $urandom_range(1, 2000);
    if (r <= 7)
      return $urandom_range(99990, 100010);
    if (r <= 10)
      q_goal = longint'(edges[$urandom_range(0, 5)]) << $urandom_range(0, 16);
    else
      q_goal = longint'($urandom_range(150, 70000)) << $urandom_range(0, 16);
    if (q_goal > 64'hFFFFFFFF)
      q_goal = 64'hFFFFFFFF;
    if (longint'(clk_hz) / q_goal == 0)
      return 32'd1;
    return 32'(longint'(clk_hz) / q_goal);
  endfunction

  function automatic logic [DUTY_W-1:0] pick_duty();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return '0;
    if (r == 1)
      return FULL_DUTY;
    if (r == 2)
      return DUTY_W'($urandom_range(65537, 131071));
    return DUTY_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return MODE_FREQ;
    if (r < 30) return MODE_DUTY;
    if (r < 65) return MODE_BOTH;
    if (r < 73) return MODE_DISABLE;
    if (r < 90) return MODE_REAPPLY;
    return MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
  endfunction

  // stimulus and verdict
  initial begin
    logic [31:0] clocks [6];
    int          counts [6];
    clocks = '{32'hFFFFFFFF, 32'd1, 32'd0, 32'd100000000, $urandom, CLOCK_RESET};
    counts = '{300, 40, 40, 400, 400, 470};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset values, range edges, saturation, every mode
    send_cmd(MODE_REAPPLY, 2'd1, 32'd0, 17'd0);
    send_cmd(MODE_FREQ, 2'd0, 32'd1000, 17'd0);
    send_cmd(MODE_BOTH, 2'd0, 32'd20000, 17'd32768);
    send_cmd(MODE_BOTH, 2'd1, 32'd0, FULL_DUTY);
    send_cmd(MODE_BOTH, 2'd2, 32'd1, 17'h1FFFF);
    send_cmd(MODE_BOTH, 2'd3, 32'hFFFFFFFF, 17'd65535);
    send_cmd(MODE_FREQ, 2'd3, 32'd99999, 17'd0);
    send_cmd(MODE_FREQ, 2'd3, 32'd100000, 17'd0);
    send_cmd(MODE_BOTH, 2'd0, 32'd80000, 17'd40000);
    send_cmd(MODE_FREQ, 2'd0, 32'd79920, 17'd0);
    send_cmd(MODE_BOTH, 2'd1, 32'd400000, FULL_DUTY);
    send_cmd(MODE_FREQ, 2'd1, 32'd398009, 17'd0);
    send_cmd(MODE_FREQ, 2'd2, 32'd1220, 17'd0);
    send_cmd(MODE_DUTY, 2'd2, 32'hFFFFFFFF, 17'd1);
    send_cmd(MODE_DUTY, 2'd3, 32'd0, 17'h1FFFF);
    send_cmd(MODE_DISABLE, 2'd3, 32'd12345, 17'd65536);
    send_cmd(MODE_SPARE_FIRST, 2'd0, 32'd5, 17'd7);
    send_cmd(MODE_SPARE_MID, 2'd1, 32'hAAAAAAAA, 17'h15555);
    send_cmd(MODE_SPARE_LAST, 2'd2, 32'h55555555, 17'h0AAAA);
    send_cmd(MODE_REAPPLY, 2'd3, 32'd0, 17'd0);
    send_cmd(MODE_BOTH, 2'd2, 32'd80000000, 17'd100);
    send_cmd(MODE_BOTH, 2'd1, 32'd40000001, 17'd30000);

    // random phases at several clock settings, extremes among them
    for (int p = 0; p < 6; p++) begin
      write_clock(clocks[p]);
      repeat (counts[p])
        send_cmd(pick_mode(), CH_W'($urandom_range(0, CHANNELS - 1)),
                 pick_freq(clock_now), pick_duty());
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
